### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the binary indexed tree block.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication a |-> b, switched off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Clocked next-cycle implication a |=> b, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/fwt_pkg.sv
// Shared types and constants for the binary indexed tree block.
// No dependencies.
`default_nettype none

package fwt_pkg;

   localparam int POS_BITS  = 11;
   localparam int DATA_BITS = 32;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### rtl/core/fwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fwt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/fwt_walk.sv
// Sequencer and shared adder that walk the tree for updates and queries,
// plus the clearing pass and the result register. Uses fwt_pkg and the macros.
`default_nettype none
`include "assert_macros.svh"

module fwt_walk
   import fwt_pkg::*;
#(
   parameter int TREE_SIZE = 1024,
   localparam int ADDR_W = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_type,
   input  wire logic        [POS_BITS-1:0]  req_position,
   input  wire logic signed [DATA_BITS-1:0] req_delta,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed      [DATA_BITS-1:0] rsp_prefix_sum,
   output logic                             ram_wr_en,
   output logic             [ADDR_W-1:0]    ram_wr_addr,
   output logic             [DATA_BITS-1:0] ram_wr_data,
   output logic                             ram_rd_en,
   output logic             [ADDR_W-1:0]    ram_rd_addr,
   input  wire logic        [DATA_BITS-1:0] ram_rd_data
);

   // walk position must hold the 11-bit input and an upward step past the top
   localparam int POS_TREE_W = $clog2(TREE_SIZE + 1) + 1;
   localparam int POS_W = (POS_TREE_W > POS_BITS) ? POS_TREE_W : POS_BITS;
   localparam logic [POS_W-1:0]  TREE_POS  = POS_W'(TREE_SIZE);
   localparam logic [ADDR_W-1:0] TREE_LAST = ADDR_W'(TREE_SIZE - 1);

   state_type state_ff, state_in;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 kind_ff, kind_in;
   logic [DATA_BITS-1:0] delta_ff, delta_in;
   logic [DATA_BITS-1:0] acc_ff, acc_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_sum_ff, rsp_sum_in;

   logic                 accept;
   logic                 issue;
   logic                 rsp_load;
   logic                 rsp_free;
   logic [POS_W-1:0]     low_bit;
   logic [POS_W-1:0]     pos_step;
   logic [POS_W-1:0]     pos_dec;
   logic [POS_W-1:0]     req_pos_ext;
   logic [DATA_BITS-1:0] add_operand;
   logic [DATA_BITS-1:0] add_sum;

   // position arithmetic
   assign low_bit  = pos_ff & (~pos_ff + POS_W'(1));
   assign pos_step = (kind_ff == REQ_QUERY) ? (pos_ff - low_bit) : (pos_ff + low_bit);
   assign pos_dec  = pos_ff - POS_W'(1);
   assign req_pos_ext = POS_W'(req_position);

   // the walk goes on while the position still lies inside the tree
   assign issue = (state_ff == ST_WALK) && (pos_ff != '0) && (pos_ff <= TREE_POS);

   // shared adder: accumulate for a query, read-modify-write for an update
   assign add_operand = (kind_ff == REQ_QUERY) ? acc_ff : delta_ff;
   assign add_sum     = ram_rd_data + add_operand;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == TREE_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!issue) begin
               state_in = (kind_ff == REQ_QUERY) ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = add_sum;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_dec[ADDR_W-1:0];
      rsp_load    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_WALK: begin
            ram_rd_en = issue;
            ram_wr_en = pend_ff && (kind_ff == REQ_UPDATE);
         end
         ST_FINISH: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      delta_in     = delta_ff;
      acc_in       = acc_ff;
      pend_in      = 1'b0;
      pend_addr_in = pos_dec[ADDR_W-1:0];
      clr_in       = clr_ff;
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      if (accept) begin
         kind_in  = req_type;
         delta_in = DATA_BITS'(req_delta);
         acc_in   = '0;
         // a query past the top covers the whole tree
         if ((req_type == REQ_QUERY) && (req_pos_ext > TREE_POS)) begin
            pos_in = TREE_POS;
         end else begin
            pos_in = req_pos_ext;
         end
      end
      if (issue) begin
         pos_in  = pos_step;
         pend_in = 1'b1;
      end
      if (pend_ff && (kind_ff == REQ_QUERY)) begin
         acc_in = add_sum;
      end
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;
      rsp_sum_in   = rsp_load ? acc_ff : rsp_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      kind_ff      <= kind_in;
      delta_ff     <= delta_in;
      acc_ff       <= acc_in;
      pend_addr_ff <= pend_addr_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prefix_sum = rsp_sum_ff;

   `ASSERT_IMPL(a_no_rw_collide, clock, reset, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "read and write hit the same entry")
   `ASSERT_IMPL(a_pend_from_issue, clock, reset, pend_ff, $past(issue), "pending read data without a read")
   `ASSERT_IMPL(a_pend_only_walk, clock, reset, state_ff != ST_WALK, !pend_ff, "read data pending outside the walk")
   `ASSERT_NEXT(a_update_climbs, clock, reset, issue && (kind_ff == REQ_UPDATE), pos_ff > $past(pos_ff), "update walk did not move upward")

endmodule

`default_nettype wire

### rtl/core/fenwick_tree_update_query.sv
// Binary indexed tree of TREE_SIZE signed 32-bit counters. After reset the
// block runs a clearing pass, one entry per cycle, and holds req_stall high
// until it ends. An item is taken in an idle cycle and then walks the tree
// through a single RAM read port and one shared adder, one entry per cycle:
// an update adds its delta to each entry on the way up to the top and yields
// no result; a query adds up the entries on the way down and then loads the
// result register, and its position saturates at TREE_SIZE. A waiting result
// does not block the next item unless that item is a query that finishes
// first. An update at position zero or past the top changes nothing; a query
// at zero returns zero and one past the top returns the sum of the whole tree.
// Depends on fwt_pkg, fwt_walk and fwt_ram.
`default_nettype none

module fenwick_tree_update_query
   import fwt_pkg::*;
#(
   parameter int TREE_SIZE = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_type,
   input  wire logic        [POS_BITS-1:0]  req_position,
   input  wire logic signed [DATA_BITS-1:0] req_delta,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed      [DATA_BITS-1:0] rsp_prefix_sum
);

   localparam int ADDR_W = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [DATA_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [DATA_BITS-1:0] ram_rd_data;

   fwt_walk #(
      .TREE_SIZE (TREE_SIZE)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_delta      (req_delta),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prefix_sum (rsp_prefix_sum),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   fwt_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (TREE_SIZE)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for fenwick_tree_update_query: directed table, then random items.
// Holds its own prefix-sum tree and checks the prefix sum of every result item.
// Depends on fwt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
   import fwt_pkg::*;

   localparam int TREE_DEPTH    = 1024;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int DRAIN_CYCLES  = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int HOLD_AT       = 150;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic                 kind;
      logic [POS_BITS-1:0]  pos;
      logic [DATA_BITS-1:0] delta;
      logic                 known;
      logic [DATA_BITS-1:0] sum;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;

   // Rows with known set carry a sum read straight off the tree contents.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{REQ_QUERY,  11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
      '{REQ_QUERY,  11'd1024, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{REQ_QUERY,  11'd2047, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{REQ_UPDATE, 11'd0,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
      '{REQ_UPDATE, 11'd1025, 32'h0000_0005, 1'b0, 32'h0000_0000},
      '{REQ_UPDATE, 11'd2047, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd2047, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{REQ_UPDATE, 11'd1,    32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
      '{REQ_UPDATE, 11'd1024, 32'h0000_0001, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd1,    32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
      '{REQ_QUERY,  11'd1024, 32'h0000_0000, 1'b1, 32'h8000_0000},
      '{REQ_QUERY,  11'd1023, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
      '{REQ_UPDATE, 11'd512,  32'h8000_0000, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd2047, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{REQ_UPDATE, 11'd1023, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
      '{REQ_UPDATE, 11'd2,    32'h0000_0002, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd1023, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd511,  32'h0000_0000, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd512,  32'h0000_0000, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd1535, 32'h0000_0000, 1'b0, 32'h0000_0000},
      '{REQ_UPDATE, 11'd1536, 32'h0000_0007, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000},
      '{REQ_QUERY,  11'd3,    32'h0000_0000, 1'b0, 32'h0000_0000},
      '{REQ_UPDATE, 11'd768,  32'h0000_0003, 1'b0, 32'h0000_0000},
      '{REQ_QUERY,  11'd767,  32'h0000_0000, 1'b0, 32'h0000_0000}
   };

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_type;
   logic        [POS_BITS-1:0]  req_position;
   logic signed [DATA_BITS-1:0] req_delta;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [DATA_BITS-1:0] rsp_prefix_sum;

   // travel with the payload so the monitor knows which rows carry a fixed sum
   logic                        req_known;
   logic        [DATA_BITS-1:0] req_known_sum;

   logic [DATA_BITS-1:0] tree_sums [1:TREE_DEPTH] = '{default: '0};
   logic [DATA_BITS-1:0] expected_sums [$];

   bit sender_burst = 1'b0;
   int updates_seen = 0;
   int queries_seen = 0;
   int sums_checked = 0;
   int mismatch_count = 0;
   int hold_cycles_done = 0;

   fenwick_tree_update_query #(
      .TREE_SIZE(TREE_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_delta      (req_delta),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prefix_sum (rsp_prefix_sum)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic void add_to_tree(input logic [POS_BITS-1:0] pos,
                                       input logic [DATA_BITS-1:0] amount);
      int unsigned k;
      k = 32'(pos);
      if (k == 0) return;
      while (k <= TREE_DEPTH) begin
         tree_sums[k] += amount;
         k += k & (~k + 1);
      end
   endfunction

   function automatic logic [DATA_BITS-1:0] prefix_total(input logic [POS_BITS-1:0] pos);
      int unsigned          k;
      logic [DATA_BITS-1:0] acc;
      k = 32'(pos);
      acc = '0;
      if (k > TREE_DEPTH) k = TREE_DEPTH;
      while (k > 0) begin
         acc += tree_sums[k];
         k -= k & (~k + 1);
      end
      return acc;
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type row;
      int unsigned  draw;
      row = '0;
      row.kind = ($urandom_range(0, 1) == 0) ? REQ_UPDATE : REQ_QUERY;
      draw = $urandom_range(0, 99);
      if (draw < 8)       row.pos = '0;
      else if (draw < 18) row.pos = POS_BITS'($urandom_range(TREE_DEPTH + 1, 2047));
      else if (draw < 40) row.pos = POS_BITS'($urandom_range(1, 16));
      else                row.pos = POS_BITS'($urandom_range(1, TREE_DEPTH));
      draw = $urandom_range(0, 99);
      if (draw < 25)      row.delta = DATA_BITS'($urandom_range(0, 20)) - 32'd10;
      else if (draw < 35) begin
         case ($urandom_range(0, 2))
            0:       row.delta = 32'h7FFF_FFFF;
            1:       row.delta = 32'h8000_0000;
            default: row.delta = 32'hFFFF_FFFF;
         endcase
      end
      else                row.delta = $urandom;
      return row;
   endfunction

   task automatic note_mismatch(input string what, input logic [DATA_BITS-1:0] want,
                                input logic [DATA_BITS-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("MISMATCH %s: expected %h, got %h", what, want, got);
   endtask

   // Sender: optional gap with valid low, then hold the item until accepted.
   task automatic send_item(input stim_row_type row);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= row.kind;
      req_position  <= row.pos;
      req_delta     <= row.delta;
      req_known     <= row.known;
      req_known_sum <= row.sum;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Receiver: random stall per result item, one long hold-off to back up the block.
   initial begin
      int n;
      int results_taken;
      bit held;
      results_taken = 0;
      held = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (((results_taken / 40) % 4) == 2) n = 0;
         else n = $urandom_range(0, 3);
         if (!held && results_taken == HOLD_AT) begin
            n = HOLD_CYCLES;
            held = 1'b1;
            hold_cycles_done = HOLD_CYCLES;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         results_taken++;
      end
   end

   // Both handshakes are handled in one process so the order within a step cannot matter.
   always @(posedge clock) begin
      logic [DATA_BITS-1:0] want;
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         if (req_type == REQ_UPDATE) begin
            add_to_tree(req_position, req_delta);
            updates_seen++;
         end else begin
            want = prefix_total(req_position);
            expected_sums.insert(expected_sums.size(), req_known ? req_known_sum : want);
            queries_seen++;
         end
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_sums.size() == 0) begin
            note_mismatch("unexpected result item", 'x, rsp_prefix_sum);
         end else begin
            want = expected_sums.pop_front();
            if (rsp_prefix_sum !== want) note_mismatch("prefix_sum", want, rsp_prefix_sum);
            sums_checked++;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= REQ_UPDATE;
      req_position  <= '0;
      req_delta     <= '0;
      req_known     <= 1'b0;
      req_known_sum <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_item(directed_rows[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_burst = ((n / 64) % 4) == 1;
         send_item(random_row());
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_sums.size() != 0) mismatch_count++;
      $display("Sent %0d directed and %0d random items: %0d updates, %0d queries",
               DIRECTED_ROWS, RANDOM_ITEMS, updates_seen, queries_seen);
      $display("Checked %0d prefix sums with a %0d-cycle receiver hold-off, %0d mismatches",
               sums_checked, hold_cycles_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
